// ===== rtl/psp_pkg.sv =====
// Shared types, codes and constants for the polyphonic sample player.
// No dependencies; the top level and the testbench refer to this package by scoped names.
`timescale 1ns / 1ps

package psp_pkg;

  // Width of intermediate frame counts and lengths (covers up to 2^24 frames)
  localparam int LEN_W   = 25;
  localparam int POS_W   = 34;
  localparam int STEP_W  = 24;
  localparam int ACC_W   = 56;
  localparam int CFG_DW  = 24;
  localparam int CFG_IW  = 3;
  localparam int MUL_AW  = 35;
  localparam int MUL_BW  = 18;
  localparam int MUL_PW  = MUL_AW + MUL_BW;

  // Input actions
  localparam logic [2:0] ACT_TICK     = 3'd0;
  localparam logic [2:0] ACT_NOTE_ON  = 3'd1;
  localparam logic [2:0] ACT_NOTE_OFF = 3'd2;
  localparam logic [2:0] ACT_ALL_OFF  = 3'd3;
  localparam logic [2:0] ACT_LOAD     = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] REG_START   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_END     = 3'd1;
  localparam logic [CFG_IW-1:0] REG_LENGTH  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_CHANNEL = 3'd3;
  localparam logic [CFG_IW-1:0] REG_LOOP    = 3'd4;
  localparam logic [CFG_IW-1:0] REG_GAIN    = 3'd5;
  localparam logic [CFG_IW-1:0] REG_ROOT    = 3'd6;
  localparam logic [CFG_IW-1:0] REG_BASE    = 3'd7;

  localparam logic [14:0] GAIN_MAX = 15'd24576;

  typedef struct packed {
    logic [2:0]         action;
    logic [6:0]         note;
    logic [15:0]        load_address;
    logic               load_channel;
    logic signed [15:0] load_value;
  } in_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic [3:0]         voices_live;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NOTE_MUL,
    S_NOTE_RND,
    S_VCHK,
    S_RD1,
    S_RD2,
    S_RD3,
    S_INTERP,
    S_SCALE,
    S_ACC,
    S_NEXT,
    S_DONE
  } state_t;

  // Semitone ratios 2^(k/12) in Q1.16
  function automatic logic [16:0] semi_ratio(input logic [3:0] k);
    logic [16:0] r;
    case (k)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd69433;
      4'd2:    r = 17'd73562;
      4'd3:    r = 17'd77936;
      4'd4:    r = 17'd82570;
      4'd5:    r = 17'd87480;
      4'd6:    r = 17'd92682;
      4'd7:    r = 17'd98193;
      4'd8:    r = 17'd104032;
      4'd9:    r = 17'd110218;
      4'd10:   r = 17'd116772;
      4'd11:   r = 17'd123715;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/psp_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module psp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/polyphonic_sample_player.sv =====
// Top level of the polyphonic sample player: voice sequencer, shared multiplier,
// mixer and configuration registers. Uses psp_pkg and psp_ram.
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  psp_pkg::in_t
// out_     output     out_valid/ out_stall psp_pkg::out_t
// cfg_     input      cfg_valid/ cfg_ready cfg_index, cfg_data
//
// A tick checks every voice slot in turn; each live voice is read, interpolated, scaled
// and accumulated once per output channel.
// One sample RAM read port and one multiplier are shared by every voice.
// A loaded note-on passes the multiply and rounding states; other non-tick items stay idle.
// Reset clears voices and sets config registers to defaults; sample RAM holds garbage until loaded.
// A finished tick waits only while an earlier result is still stalled.

module polyphonic_sample_player #(
  parameter int NUM_VOICES   = 8,
  parameter int SAMPLE_DEPTH = 65536,
  parameter int OUT_CHANNELS = 2,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  psp_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output psp_pkg::out_t               out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [psp_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [psp_pkg::CFG_DW-1:0]  cfg_data
);

  localparam int VW     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int AW     = $clog2(SAMPLE_DEPTH);
  localparam int RAM_D  = 2 << AW;
  localparam int LEN_W  = psp_pkg::LEN_W;
  localparam int POS_W  = psp_pkg::POS_W;
  localparam int ACC_W  = psp_pkg::ACC_W;
  localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(SAMPLE_DEPTH);
  localparam logic [15:0] LOAD_MASK =
    (SAMPLE_BITS >= 16) ? 16'hFFFF : 16'(~((32'd1 << (16 - SAMPLE_BITS)) - 32'd1));

  // Configuration registers
  logic [15:0] start_r;
  logic [16:0] end_r;
  logic [16:0] length_r;
  logic [1:0]  chan_r;
  logic        loop_r;
  logic [14:0] gain_r;
  logic [6:0]  root_r;
  logic [23:0] base_r;

  // Voice state
  logic              live_r [NUM_VOICES];
  logic [6:0]        vnote_r [NUM_VOICES];
  logic [POS_W-1:0]  vpos_r [NUM_VOICES];
  logic [23:0]       vstep_r [NUM_VOICES];

  // Sequencer
  psp_pkg::state_t state_r, state_nxt;
  logic [VW-1:0]     vcnt_r;
  logic              ch_r;
  logic [AW-1:0]     idx_r, nxt_r;
  logic [15:0]       frac_r;
  logic [POS_W-1:0]  pos_r;
  logic signed [15:0] s1_r, s2_r;
  logic signed [psp_pkg::MUL_PW-1:0] mprod_r;
  logic signed [ACC_W-1:0] acc_r [2];
  logic [3:0]        live_cnt_r;
  logic [15:0]       st_r;
  logic [LEN_W-1:0]  len_r, lim_r;
  logic              loopok_r, stereo_r;
  logic [14:0]       g_r;

  // Note-on bookkeeping
  logic [VW-1:0]     nv_idx_r;
  logic              nv_found_r;
  logic [6:0]        nnote_r;
  logic [3:0]        k_r;
  logic [4:0]        sh_r;

  logic              out_valid_r;
  psp_pkg::out_t     out_data_r;

  logic in_acc;
  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != psp_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Effective length and play window, from configuration
  logic [LEN_W-1:0] eff_len, endr, lim, st_l;
  logic             loopok;
  always_comb begin
    st_l    = LEN_W'(start_r);
    eff_len = (LEN_W'(length_r) > DEPTH_L) ? DEPTH_L : LEN_W'(length_r);
    endr    = (LEN_W'(end_r) > st_l) ? LEN_W'(end_r) : eff_len;
    lim     = (endr < eff_len) ? endr : eff_len;
    loopok  = loop_r && (endr > st_l) && (st_l < lim);
  end

  // Kill matching voices and find the lowest free voice
  logic [NUM_VOICES-1:0] match_v, after_kill;
  logic [VW-1:0]         free_idx;
  logic                  free_found;
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = 0; i < NUM_VOICES; i++) begin
      match_v[i]    = live_r[i] && (vnote_r[i] == in_data.note);
      after_kill[i] = live_r[i] && !match_v[i];
    end
    for (int i = NUM_VOICES - 1; i >= 0; i--) begin
      if (!after_kill[i]) begin
        free_idx   = VW'(i);
        free_found = 1'b1;
      end
    end
  end

  // Octave and semitone of (note - root): floor division by 12 via reciprocal
  logic signed [7:0] pd;
  logic [8:0]        pdp;
  logic [15:0]       pq_prod;
  logic [4:0]        pq;
  logic [8:0]        pk;
  always_comb begin
    pd      = 8'($signed({1'b0, in_data.note}) - $signed({1'b0, root_r}));
    pdp     = {pd[7], pd} + 9'd132;
    pq_prod = 16'(pdp) * 16'd171;
    pq      = pq_prod[15:11];
    pk      = pdp - 9'(pq) * 9'd12;
  end

  // Current voice window check
  logic [POS_W-1:0] vc_pos;
  logic [17:0]      vc_idx;
  logic             vc_past, vc_retire;
  logic [LEN_W-1:0] vc_nxt;
  always_comb begin
    vc_pos = vpos_r[vcnt_r];
    if (LEN_W'(vc_pos[33:16]) < LEN_W'(st_r)) begin
      vc_pos = {2'b00, st_r, 16'h0000};
    end
    vc_past = (LEN_W'(vc_pos[33:16]) >= lim_r);
    if (vc_past && loopok_r) begin
      vc_pos = {2'b00, st_r, 16'h0000};
    end
    vc_retire = vc_past && !loopok_r;
    vc_idx    = vc_pos[33:16];
    vc_nxt    = (LEN_W'(vc_idx) + 1'b1 < len_r) ? LEN_W'(vc_idx) + 1'b1 : len_r - 1'b1;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      psp_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_data.action == psp_pkg::ACT_NOTE_ON && eff_len != '0) begin
            state_nxt = psp_pkg::S_NOTE_MUL;
          end else if (in_data.action == psp_pkg::ACT_TICK) begin
            state_nxt = psp_pkg::S_VCHK;
          end
        end
      end
      psp_pkg::S_NOTE_MUL: state_nxt = psp_pkg::S_NOTE_RND;
      psp_pkg::S_NOTE_RND: state_nxt = psp_pkg::S_IDLE;
      psp_pkg::S_VCHK: begin
        if (!live_r[vcnt_r] || vc_retire) begin
          state_nxt = psp_pkg::S_NEXT;
        end else begin
          state_nxt = psp_pkg::S_RD1;
        end
      end
      psp_pkg::S_RD1:    state_nxt = psp_pkg::S_RD2;
      psp_pkg::S_RD2:    state_nxt = psp_pkg::S_RD3;
      psp_pkg::S_RD3:    state_nxt = psp_pkg::S_INTERP;
      psp_pkg::S_INTERP: state_nxt = psp_pkg::S_SCALE;
      psp_pkg::S_SCALE:  state_nxt = psp_pkg::S_ACC;
      psp_pkg::S_ACC: begin
        if (!ch_r && OUT_CHANNELS >= 2) begin
          state_nxt = psp_pkg::S_RD1;
        end else begin
          state_nxt = psp_pkg::S_NEXT;
        end
      end
      psp_pkg::S_NEXT: begin
        if (32'(vcnt_r) == NUM_VOICES - 1) begin
          state_nxt = psp_pkg::S_DONE;
        end else begin
          state_nxt = psp_pkg::S_VCHK;
        end
      end
      psp_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = psp_pkg::S_IDLE;
        end
      end
      default: state_nxt = psp_pkg::S_IDLE;
    endcase
  end

  // Datapath controls: RAM ports and shared multiplier operands
  logic                         ram_we;
  logic [AW:0]                  ram_waddr, ram_raddr;
  logic [15:0]                  ram_wdata, ram_rdata;
  logic signed [psp_pkg::MUL_AW-1:0] mul_a;
  logic signed [psp_pkg::MUL_BW-1:0] mul_b;
  logic signed [16:0]           diff;
  logic signed [33:0]           interp_v;
  logic [LEN_W-1:0]             load_addr_l;
  always_comb begin
    load_addr_l = LEN_W'(in_data.load_address);
    ram_we      = in_acc && (in_data.action == psp_pkg::ACT_LOAD) && (load_addr_l < DEPTH_L);
    ram_waddr   = {in_data.load_channel, load_addr_l[AW-1:0]};
    ram_wdata   = in_data.load_value & LOAD_MASK;
    ram_raddr   = {ch_r && stereo_r, (state_r == psp_pkg::S_RD1) ? idx_r : nxt_r};
    diff        = 17'(s2_r) - 17'(s1_r);
    interp_v    = $signed({{2{s1_r[15]}}, s1_r, 16'h0000}) + $signed(mprod_r[33:0]);
    mul_a       = '0;
    mul_b       = '0;
    case (state_r)
      psp_pkg::S_NOTE_MUL: begin
        mul_a = $signed({11'b0, base_r});
        mul_b = $signed({1'b0, psp_pkg::semi_ratio(k_r)});
      end
      psp_pkg::S_INTERP: begin
        mul_a = psp_pkg::MUL_AW'(diff);
        mul_b = $signed({2'b00, frac_r});
      end
      psp_pkg::S_SCALE: begin
        mul_a = psp_pkg::MUL_AW'(interp_v);
        mul_b = $signed({3'b000, g_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  psp_ram #(
    .WIDTH(16),
    .DEPTH(RAM_D)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Pitch step rounding and saturation
  logic [41:0] p_rnd, p_shift;
  logic [23:0] p_step;
  always_comb begin
    p_rnd   = 42'(mprod_r[40:0]) + (42'd1 << (sh_r - 5'd1));
    p_shift = p_rnd >> sh_r;
    if (p_shift > 42'hFFFFFF) begin
      p_step = 24'hFFFFFF;
    end else begin
      p_step = p_shift[23:0];
    end
    if (p_step == '0 && base_r != '0) begin
      p_step = 24'd1;
    end
  end

  // Output rounding to Q1.15 with saturation
  logic signed [ACC_W-1:0] rnd_l, rnd_r;
  logic signed [15:0]      q_l, q_r;
  always_comb begin
    rnd_l = (acc_r[0] + ACC_W'(64'sd536870912)) >>> 30;
    rnd_r = (acc_r[1] + ACC_W'(64'sd536870912)) >>> 30;
    if (rnd_l > ACC_W'(64'sd32767)) q_l = 16'sh7FFF;
    else if (rnd_l < ACC_W'(-64'sd32768)) q_l = 16'sh8000;
    else q_l = rnd_l[15:0];
    if (rnd_r > ACC_W'(64'sd32767)) q_r = 16'sh7FFF;
    else if (rnd_r < ACC_W'(-64'sd32768)) q_r = 16'sh8000;
    else q_r = rnd_r[15:0];
  end

  // State, control and voice registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psp_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      start_r     <= 16'd0;
      end_r       <= 17'd65536;
      length_r    <= 17'd0;
      chan_r      <= 2'd1;
      loop_r      <= 1'b0;
      gain_r      <= 15'd16384;
      root_r      <= 7'd60;
      base_r      <= 24'd65536;
      for (int i = 0; i < NUM_VOICES; i++) begin
        live_r[i] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;

      // Configuration writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          psp_pkg::REG_START:   start_r  <= cfg_data[15:0];
          psp_pkg::REG_END:     end_r    <= cfg_data[16:0];
          psp_pkg::REG_LENGTH:  length_r <= cfg_data[16:0];
          psp_pkg::REG_CHANNEL: chan_r   <= cfg_data[1:0];
          psp_pkg::REG_LOOP:    loop_r   <= cfg_data[0];
          psp_pkg::REG_GAIN:    gain_r   <= cfg_data[14:0];
          psp_pkg::REG_ROOT:    root_r   <= cfg_data[6:0];
          psp_pkg::REG_BASE:    base_r   <= cfg_data[23:0];
          default: ;
        endcase
      end

      // Output register: loaded at the end of a tick, cleared on transfer
      if (state_r == psp_pkg::S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        psp_pkg::S_IDLE: begin
          if (in_acc) begin
            if ((in_data.action == psp_pkg::ACT_NOTE_ON && eff_len != '0) ||
                in_data.action == psp_pkg::ACT_NOTE_OFF) begin
              for (int i = 0; i < NUM_VOICES; i++) begin
                live_r[i] <= after_kill[i];
              end
            end else if (in_data.action == psp_pkg::ACT_ALL_OFF) begin
              for (int i = 0; i < NUM_VOICES; i++) begin
                live_r[i] <= 1'b0;
              end
            end
          end
        end
        psp_pkg::S_NOTE_RND: begin
          if (nv_found_r) begin
            live_r[nv_idx_r] <= 1'b1;
          end
        end
        psp_pkg::S_VCHK: begin
          if (live_r[vcnt_r] && vc_retire) begin
            live_r[vcnt_r] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    mprod_r <= mul_a * mul_b;
    if (state_r == psp_pkg::S_DONE && (!out_valid_r || !out_stall)) begin
      out_data_r.left_out    <= q_l;
      out_data_r.right_out   <= (OUT_CHANNELS >= 2) ? q_r : 16'sd0;
      out_data_r.voices_live <= live_cnt_r;
    end
    case (state_r)
      psp_pkg::S_IDLE: begin
        nv_idx_r   <= free_idx;
        nv_found_r <= free_found;
        nnote_r    <= in_data.note;
        k_r        <= pk[3:0];
        sh_r       <= 5'd27 - pq;
        acc_r[0]   <= '0;
        acc_r[1]   <= '0;
        live_cnt_r <= 4'd0;
        vcnt_r     <= '0;
        ch_r       <= 1'b0;
        st_r       <= start_r;
        len_r      <= eff_len;
        lim_r      <= lim;
        loopok_r   <= loopok;
        stereo_r   <= (chan_r >= 2'd2);
        g_r        <= (gain_r > psp_pkg::GAIN_MAX) ? psp_pkg::GAIN_MAX : gain_r;
      end
      psp_pkg::S_NOTE_RND: begin
        if (nv_found_r) begin
          vnote_r[nv_idx_r] <= nnote_r;
          vpos_r[nv_idx_r]  <= {2'b00, start_r, 16'h0000};
          vstep_r[nv_idx_r] <= p_step;
        end
      end
      psp_pkg::S_VCHK: begin
        pos_r  <= vc_pos;
        idx_r  <= vc_idx[AW-1:0] & {AW{1'b1}};
        nxt_r  <= vc_nxt[AW-1:0];
        frac_r <= vc_pos[15:0];
        ch_r   <= 1'b0;
      end
      psp_pkg::S_RD2: s1_r <= ram_rdata;
      psp_pkg::S_RD3: s2_r <= ram_rdata;
      psp_pkg::S_ACC: begin
        acc_r[ch_r] <= acc_r[ch_r] + ACC_W'(mprod_r);
        if (!ch_r && OUT_CHANNELS >= 2) begin
          ch_r <= 1'b1;
        end else begin
          vpos_r[vcnt_r] <= pos_r + POS_W'((vstep_r[vcnt_r] != '0) ?
                                           vstep_r[vcnt_r] : 24'd65536);
          live_cnt_r <= live_cnt_r + 4'd1;
        end
      end
      psp_pkg::S_NEXT: vcnt_r <= vcnt_r + 1'b1;
      default: ;
    endcase
  end

  // A result appears only at the end of a tick.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == psp_pkg::S_DONE))
    else $error("result raised outside tick completion");

  // Leaving the done state always presents a result.
  a_done_presents: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psp_pkg::S_DONE && (!out_valid_r || !out_stall)) |=> out_valid_r)
    else $error("finished tick produced no result");

  // Sample reads come in order: the second read follows the first.
  a_read_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psp_pkg::S_RD2) |-> $past(state_r == psp_pkg::S_RD1))
    else $error("sample read sequence broken");

endmodule

// ===== sim/polyphonic_sample_player_tb.sv =====
// Self-checking testbench for polyphonic_sample_player.
// Depends on psp_pkg and the player RTL; a mix predictor checks every tick result.
`timescale 1ns / 1ps

module polyphonic_sample_player_tb;

  // Tracks voices, registers and sample memory, and predicts each tick's mix.
  class mix_predictor;
    shortint     mem [2*65536];
    bit          live [8];
    bit [6:0]    vnote [8];
    longint unsigned vpos [8];
    int unsigned vstep [8];
    int unsigned start_fr, end_fr, length, chans, loop_on, gain, root, base;
    psp_pkg::out_t expected_mix [$];
    int          errors;

    function new();
      start_fr = 0; end_fr = 65536; length = 0; chans = 1;
      loop_on = 0; gain = 16384; root = 60; base = 65536;
      errors = 0;
      foreach (live[i]) begin
        live[i] = 0; vnote[i] = 0; vpos[i] = 0; vstep[i] = 0;
      end
    endfunction

    function void set_reg(logic [psp_pkg::CFG_IW-1:0] idx, int unsigned v);
      case (idx)
        psp_pkg::REG_START:   start_fr = v & 16'hFFFF;
        psp_pkg::REG_END:     end_fr = v & 17'h1FFFF;
        psp_pkg::REG_LENGTH:  length = v & 17'h1FFFF;
        psp_pkg::REG_CHANNEL: chans = v & 3;
        psp_pkg::REG_LOOP:    loop_on = v & 1;
        psp_pkg::REG_GAIN:    gain = v & 15'h7FFF;
        psp_pkg::REG_ROOT:    root = v & 7'h7F;
        default:              base = v & 24'hFFFFFF;
      endcase
    endfunction

    function longint unsigned eff_len();
      return (length > 65536) ? 65536 : length;
    endfunction

    // Pitch ratio for a note relative to the root, in Q8.16 frames per tick.
    function int unsigned note_step(bit [6:0] n);
      int unsigned semitone [12] = '{65536, 69433, 73562, 77936, 82570, 87480,
                                     92682, 98193, 104032, 110218, 116772, 123715};
      int d, oct, k, sh;
      longint unsigned p, r;
      d = int'(n) - int'(root);
      oct = (d >= 0) ? d / 12 : -((11 - d) / 12);
      k = d - 12 * oct;
      sh = 16 - oct;
      p = longint'(base) * semitone[k];
      r = (p + (64'd1 << (sh - 1))) >> sh;
      if (r > 64'hFFFFFF) r = 64'hFFFFFF;
      if (r == 0 && base != 0) r = 1;
      return int'(r);
    endfunction

    function int sat_q15(longint acc);
      longint v;
      v = (acc + (64'sd1 <<< 29)) >>> 30;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return int'(v);
    endfunction

    function void mix_tick();
      longint acc [2];
      longint unsigned len, st, endr, lim, p, idx, nxt, frac, stp, b;
      longint s1, s2;
      int unsigned g, n;
      psp_pkg::out_t r;
      acc[0] = 0; acc[1] = 0; n = 0;
      len = eff_len();
      st = start_fr;
      endr = (end_fr > start_fr) ? end_fr : len;
      lim = (endr < len) ? endr : len;
      g = (gain > 24576) ? 24576 : gain;
      for (int i = 0; i < 8; i++) begin
        if (!live[i]) continue;
        p = vpos[i];
        if ((p >> 16) < st) p = st << 16;
        idx = p >> 16;
        if (idx >= lim) begin
          if (loop_on != 0 && endr > st && st < lim) begin
            p = st << 16;
            idx = st;
          end else begin
            live[i] = 0;
            continue;
          end
        end
        nxt = (idx + 1 < len) ? idx + 1 : len - 1;
        frac = p & 16'hFFFF;
        for (int c = 0; c < 2; c++) begin
          b = (c == 1 && chans >= 2) ? 65536 : 0;
          s1 = mem[b + idx];
          s2 = mem[b + nxt];
          acc[c] += (s1 * 65536 + (s2 - s1) * longint'(frac)) * longint'(g);
        end
        stp = (vstep[i] != 0) ? vstep[i] : 65536;
        vpos[i] = (p + stp) & 34'h3FFFFFFFF;
        n++;
      end
      r.left_out = 16'(sat_q15(acc[0]));
      r.right_out = 16'(sat_q15(acc[1]));
      r.voices_live = 4'(n);
      expected_mix = {expected_mix, r};
    endfunction

    // Notes one accepted input transfer.
    function void take_item(psp_pkg::in_t x);
      bit done;
      case (x.action)
        psp_pkg::ACT_TICK: mix_tick();
        psp_pkg::ACT_NOTE_ON: begin
          if (eff_len() != 0) begin
            foreach (live[i]) if (live[i] && vnote[i] == x.note) live[i] = 0;
            done = 0;
            foreach (live[i]) begin
              if (!done && !live[i]) begin
                live[i] = 1;
                vnote[i] = x.note;
                vpos[i] = longint'(start_fr) << 16;
                vstep[i] = note_step(x.note);
                done = 1;
              end
            end
          end
        end
        psp_pkg::ACT_NOTE_OFF:
          foreach (live[i]) if (live[i] && vnote[i] == x.note) live[i] = 0;
        psp_pkg::ACT_ALL_OFF: foreach (live[i]) live[i] = 0;
        psp_pkg::ACT_LOAD: mem[{x.load_channel, x.load_address}] = x.load_value;
        default: ;
      endcase
    endfunction

    // Compares one accepted result transfer with the oldest expected mix.
    function void check_mix(psp_pkg::out_t got);
      psp_pkg::out_t e;
      if (expected_mix.size() == 0) begin
        $error("unexpected result transfer %h", got);
        errors++;
        return;
      end
      e = expected_mix.pop_front();
      if (got.left_out !== e.left_out) begin
        $error("left_out expected %0d got %0d", e.left_out, got.left_out);
        errors++;
      end
      if (got.right_out !== e.right_out) begin
        $error("right_out expected %0d got %0d", e.right_out, got.right_out);
        errors++;
      end
      if (got.voices_live !== e.voices_live) begin
        $error("voices_live expected %0d got %0d", e.voices_live, got.voices_live);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  psp_pkg::in_t  in_item = '0;
  logic out_valid;
  logic out_stall = 0;
  psp_pkg::out_t out_item;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [psp_pkg::CFG_IW-1:0] cfg_index = psp_pkg::REG_START;
  logic [psp_pkg::CFG_DW-1:0] cfg_data = '0;

  mix_predictor pred = new();
  bit hold_req = 0;

  polyphonic_sample_player DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // Mostly no gap, some short gaps, a few long ones.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver back-pressure, with one long hold-off on request.
  initial begin
    int g;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1;
        repeat (500) @(posedge clk);
        hold_req = 0;
      end else begin
        g = gap_len();
        if (g > 0) begin
          out_stall <= 1;
          repeat (g - 1) @(posedge clk);
        end else begin
          out_stall <= 0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) pred.check_mix(out_item);
  end

  function automatic psp_pkg::in_t make_item(logic [2:0] act, logic [6:0] n);
    psp_pkg::in_t x;
    x.action = act;
    x.note = n;
    x.load_address = 16'($urandom);
    x.load_channel = 1'($urandom);
    x.load_value = 16'($urandom);
    return x;
  endfunction

  // One input transfer, followed by a random gap.
  task automatic send(psp_pkg::in_t x);
    int g;
    in_item <= x;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred.take_item(x);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic load(int addr, bit ch, int v);
    psp_pkg::in_t x;
    x = make_item(psp_pkg::ACT_LOAD, 7'($urandom));
    x.load_address = 16'(addr);
    x.load_channel = ch;
    x.load_value = 16'(v);
    send(x);
  endtask

  task automatic cfg_write(logic [psp_pkg::CFG_IW-1:0] idx, int unsigned v);
    cfg_index <= idx;
    cfg_data <= psp_pkg::CFG_DW'(v);
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pred.set_reg(idx, v);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Waits until every expected mix has arrived and the block has settled.
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pred.expected_mix.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // Sets all registers, loads frames [lo, hi) on both channels, then sends random ticks, notes and other items.
  task automatic play_phase(int unsigned st, int unsigned en, int unsigned len,
                            int unsigned ch, int unsigned lp, int unsigned g,
                            int unsigned rt, int unsigned bs, int lo, int hi, int count);
    int r, v;
    logic [6:0] n, last_note;
    drain();
    cfg_write(psp_pkg::REG_START, st);
    cfg_write(psp_pkg::REG_END, en);
    cfg_write(psp_pkg::REG_LENGTH, len);
    cfg_write(psp_pkg::REG_CHANNEL, ch);
    cfg_write(psp_pkg::REG_LOOP, lp);
    cfg_write(psp_pkg::REG_GAIN, g);
    cfg_write(psp_pkg::REG_ROOT, rt);
    cfg_write(psp_pkg::REG_BASE, bs);
    for (int a = lo; a < hi; a++) begin
      for (int c = 0; c < 2; c++) begin
        r = $urandom_range(0, 9);
        v = (r == 0) ? 32767 : (r == 1) ? -32768 : int'(16'($urandom));
        load(a, c[0], v);
      end
    end
    last_note = 7'(rt);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      n = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'(int'(rt) + $urandom_range(0, 24) - 12);
      if (r < 50) send(make_item(psp_pkg::ACT_TICK, n));
      else if (r < 75) begin
        send(make_item(psp_pkg::ACT_NOTE_ON, n));
        last_note = n;
      end
      else if (r < 87)
        send(make_item(psp_pkg::ACT_NOTE_OFF, ($urandom_range(0, 1) != 0) ? last_note : n));
      else if (r < 90) send(make_item(psp_pkg::ACT_ALL_OFF, n));
      else if (r < 96) send(make_item(psp_pkg::ACT_LOAD, n));
      else send(make_item(3'($urandom_range(5, 7)), n));
    end
  endtask

  initial begin
    int seq;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Length still zero: notes are ignored and ticks mix silence.
    load(0, 0, 32767);
    load(65535, 1, -32768);
    load(65535, 0, 32767);
    send(make_item(psp_pkg::ACT_NOTE_ON, 7'd60));
    send(make_item(psp_pkg::ACT_TICK, 7'd0));
    send(make_item(3'd5, 7'd1));
    send(make_item(3'd6, 7'd2));
    send(make_item(3'd7, 7'd127));
    send(make_item(psp_pkg::ACT_NOTE_OFF, 7'd60));
    send(make_item(psp_pkg::ACT_ALL_OFF, 7'd0));

    // Short looped mono selection; fill every voice, overflow, retrigger, release.
    play_phase(0, 0, 16, 1, 1, 24576, 60, 65536, 0, 16, 0);
    for (int i = 0; i < 9; i++) send(make_item(psp_pkg::ACT_NOTE_ON, 7'(i * 15)));
    send(make_item(psp_pkg::ACT_TICK, 7'd0));
    send(make_item(psp_pkg::ACT_NOTE_ON, 7'd0));
    send(make_item(psp_pkg::ACT_NOTE_OFF, 7'd15));
    send(make_item(psp_pkg::ACT_TICK, 7'd0));
    send(make_item(psp_pkg::ACT_ALL_OFF, 7'd0));
    send(make_item(psp_pkg::ACT_TICK, 7'd0));
    play_phase(0, 0, 16, 1, 1, 24576, 60, 65536, 0, 0, 60);

    // Long output hold while ticks keep coming, so the block fills and stalls its input.
    hold_req = 1;
    repeat (8) send(make_item(psp_pkg::ACT_TICK, 7'd0));

    // Stereo window without looping, clamped gain, saturated steps.
    play_phase(4, 12, 20, 2, 0, 32767, 0, 16777215, 0, 20, 60);
    // Top of memory, oversized length, slowest nonzero step.
    play_phase(65520, 65536, 100000, 3, 1, 0, 127, 1, 65520, 65536, 30);
    play_phase(65535, 65536, 65536, 2, 1, 20000, 64, 3000000, 65520, 65520, 30);
    // End below start falls back to the length; mono; zero step.
    play_phase(10, 5, 24, 0, 1, 12345, 127, 0, 0, 24, 50);
    // Start beyond the loaded length: voices retire at once.
    play_phase(30, 40, 20, 2, 1, 16384, 60, 65536, 0, 0, 20);
    // Random settings over a small region.
    for (seq = 0; seq < 2; seq++)
      play_phase($urandom_range(0, 8), $urandom_range(0, 32), $urandom_range(9, 32),
                 $urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(0, 32767),
                 $urandom_range(0, 127), $urandom_range(0, 400000), 0, 32, 25);

    drain();
    if (pred.errors == 0 && pred.expected_mix.size() == 0)
      $display("polyphonic_sample_player: match");
    else
      $display("polyphonic_sample_player: mismatch");
    $finish;
  end

  initial begin
    #40ms;
    $display("polyphonic_sample_player: mismatch");
    $finish;
  end

endmodule
